// ===== src/cfsg_pkg.sv =====
// Shared types and constants for the filled-disc column span generator.
package cfsg_pkg;

  // Largest disc radius the datapath is sized for
  localparam int MAX_RADIUS_DEF = 32;

  // Field widths fixed by the stream format
  localparam int CX_W    = 12;
  localparam int CY_W    = 12;
  localparam int RAD_W   = 6;
  localparam int COLOR_W = 24;
  localparam int COL_W   = 14;
  localparam int ROW_W   = 13;
  localparam int SCR_W   = 13;

  // Packed stream widths, rounded up to whole bytes
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 8'd1;

  // Reset values of the screen size registers
  localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROOT,
    ST_FIN,
    ST_EMIT
  } state_t;

endpackage

// ===== src/circle_fill_span_generator_core.sv =====
// Filled-disc column span generator: one span beat per column of a disc.
//
//  channel | direction | payload                                   | handshake
//  in_     | slave     | center_x, center_y, radius, fill_color    | in_tvalid/in_tready
//  out_    | master    | column_x, span_top, span_bottom, color    | out_tvalid/out_tready
//          |           | tuser = span_valid, tlast = last_span     |
//  cfg_    | slave     | cfg_index, cfg_data (screen size regs)    | cfg_valid/cfg_ready
//
// Each column runs through the sequencer states in order: form r*r - d*d,
// six passes through the shared square-root step, finish the span and
// hold the result beat until the sink takes it.
// A disc of radius r (saturated to MAX_RADIUS) gives 2*r column beats.
// rst_n is synchronous and active low; screen size resets to 640 x 480.
// A stalled out_ beat holds the sequencer; in_tready is low until the last
// span of a disc has been taken. A zero radius is taken and gives no beat.
module circle_fill_span_generator_core #(
  parameter int MAX_RADIUS = cfsg_pkg::MAX_RADIUS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: center_x[11:0], center_y[23:12], radius[29:24], fill_color[53:30]
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [cfsg_pkg::IN_DATA_W-1:0]        in_tdata,
  // out_tdata: column_x[13:0], span_top[26:14], span_bottom[39:27],
  //            span_color[63:40]
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [cfsg_pkg::OUT_DATA_W-1:0]       out_tdata,
  // out_tuser: span_valid[0]
  output logic                                  out_tuser,
  output logic                                  out_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cfsg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cfsg_pkg::SCR_W-1:0]            cfg_data
);

  // Widths derived from the largest radius
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int OW    = $clog2(2 * MAX_RADIUS);
  localparam int DW    = OW + 1;
  localparam int SW    = $clog2(MAX_RADIUS * MAX_RADIUS + 1);
  localparam int NSTEP = (SW + 1) / 2;
  localparam int SCW   = $clog2(NSTEP + 1);
  localparam int AW    = 2 * NSTEP + 1;

  localparam int COL_W = cfsg_pkg::COL_W;
  localparam int ROW_W = cfsg_pkg::ROW_W;

  cfsg_pkg::state_t state_r, state_nxt;

  logic [cfsg_pkg::SCR_W-1:0]   scr_width_r;
  logic [cfsg_pkg::SCR_W-1:0]   scr_height_r;

  logic [cfsg_pkg::CX_W-1:0]    cx_r;
  logic [cfsg_pkg::CY_W-1:0]    cy_r;
  logic [RW-1:0]                rad_r;
  logic [SW-1:0]                rsq_r;
  logic [cfsg_pkg::COLOR_W-1:0] color_r;
  logic [OW-1:0]                offset_r;
  logic signed [DW-1:0]         d_r;
  logic                         last_r;

  logic [SW-1:0]                rem_r;
  logic [AW-1:0]                res_r;
  logic [SCW-1:0]               step_r;

  logic [COL_W-1:0]             col_x_r;
  logic [ROW_W-1:0]             top_r;
  logic [ROW_W-1:0]             bottom_r;
  logic                         span_ok_r;
  logic                         out_last_r;

  // Input field split
  logic [cfsg_pkg::CX_W-1:0]    in_cx;
  logic [cfsg_pkg::CY_W-1:0]    in_cy;
  logic [cfsg_pkg::RAD_W-1:0]   in_rad;
  logic [cfsg_pkg::COLOR_W-1:0] in_color;
  logic [RW-1:0]                in_rad_sat;
  logic                         in_beat;
  logic                         out_beat;

  assign in_cx    = in_tdata[11:0];
  assign in_cy    = in_tdata[23:12];
  assign in_rad   = in_tdata[29:24];
  assign in_color = in_tdata[53:30];
  assign in_rad_sat = (in_rad > cfsg_pkg::RAD_W'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                               : RW'(in_rad);
  assign in_beat  = in_tvalid && in_tready;
  assign out_beat = out_tvalid && out_tready;

  // Column offset d = offset - r and its magnitude
  logic signed [DW-1:0] d_cur;
  logic [RW-1:0]        d_abs;
  logic [SW-1:0]        d_sq;

  assign d_cur = $signed({1'b0, offset_r}) - $signed(DW'({1'b0, rad_r}));
  assign d_abs = d_cur[DW-1] ? RW'(-d_cur) : RW'(d_cur);
  assign d_sq  = SW'(d_abs * d_abs);

  // Shared square-root step: one result bit per pass
  logic [AW-1:0] root_bit;
  logic [AW-1:0] root_trial;
  logic          root_take;
  logic [SW-1:0] rem_step;
  logic [AW-1:0] res_step;

  assign root_bit   = AW'(1) << (2 * step_r);
  assign root_trial = res_r + root_bit;
  assign root_take  = AW'(rem_r) >= root_trial;
  assign rem_step   = root_take ? SW'(AW'(rem_r) - root_trial) : rem_r;
  assign res_step   = root_take ? ((res_r >> 1) + root_bit) : (res_r >> 1);

  // Span finish: ceil root, rows, column and clipping
  logic [ROW_W-1:0]        fl_root;
  logic [ROW_W-1:0]        cl_root;
  logic [ROW_W-1:0]        top_c;
  logic [ROW_W-1:0]        bottom_c;
  logic [COL_W-1:0]        col_x_c;
  logic                    clip_c;

  assign fl_root  = ROW_W'(res_r);
  assign cl_root  = fl_root + ROW_W'(rem_r != '0);
  assign top_c    = ROW_W'({1'b0, cy_r}) - cl_root;
  assign bottom_c = ROW_W'({1'b0, cy_r}) + fl_root;
  assign col_x_c  = COL_W'({2'b00, cx_r}) + {{(COL_W - DW){d_r[DW-1]}}, d_r};
  assign clip_c   = (bottom_c > scr_height_r) || top_c[ROW_W-1] ||
                    col_x_c[COL_W-1] ||
                    (!col_x_c[COL_W-1] && (col_x_c[ROW_W-1:0] >= scr_width_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfsg_pkg::ST_IDLE: begin
        if (in_beat && (in_rad != '0)) state_nxt = cfsg_pkg::ST_LOAD;
      end
      cfsg_pkg::ST_LOAD: state_nxt = cfsg_pkg::ST_ROOT;
      cfsg_pkg::ST_ROOT: begin
        if (step_r == '0) state_nxt = cfsg_pkg::ST_FIN;
      end
      cfsg_pkg::ST_FIN:  state_nxt = cfsg_pkg::ST_EMIT;
      cfsg_pkg::ST_EMIT: begin
        if (out_beat) state_nxt = out_last_r ? cfsg_pkg::ST_IDLE : cfsg_pkg::ST_LOAD;
      end
      default: state_nxt = cfsg_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      cfsg_pkg::ST_IDLE: in_tready  = 1'b1;
      cfsg_pkg::ST_EMIT: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;
  assign out_tdata = {color_r, bottom_r, top_r, col_x_r};
  assign out_tuser = span_ok_r;
  assign out_tlast = out_last_r;

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cfsg_pkg::ST_IDLE;
      scr_width_r  <= cfsg_pkg::SCREEN_WIDTH_RST;
      scr_height_r <= cfsg_pkg::SCREEN_HEIGHT_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          cfsg_pkg::CFG_SCREEN_WIDTH:  scr_width_r  <= cfg_data;
          cfsg_pkg::CFG_SCREEN_HEIGHT: scr_height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Latch the disc, walk the columns, run the root and hold the span
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cx_r     <= in_cx;
      cy_r     <= in_cy;
      rad_r    <= in_rad_sat;
      rsq_r    <= SW'(in_rad_sat * in_rad_sat);
      color_r  <= in_color;
      offset_r <= '0;
    end
    if (state_r == cfsg_pkg::ST_LOAD) begin
      d_r    <= d_cur;
      rem_r  <= rsq_r - d_sq;
      res_r  <= '0;
      step_r <= SCW'(NSTEP - 1);
      last_r <= (d_cur == $signed(DW'({1'b0, rad_r})) - DW'(1));
    end
    if (state_r == cfsg_pkg::ST_ROOT) begin
      rem_r  <= rem_step;
      res_r  <= res_step;
      step_r <= step_r - SCW'(1);
    end
    if (state_r == cfsg_pkg::ST_FIN) begin
      col_x_r    <= col_x_c;
      top_r      <= top_c;
      bottom_r   <= bottom_c;
      span_ok_r  <= !clip_c;
      out_last_r <= last_r;
    end
    if (out_beat) begin
      offset_r <= offset_r + OW'(1);
    end
  end

  // Checks on sequencer and span results
  a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while a span is pending");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (state_r == cfsg_pkg::ST_IDLE))
    else $error("sequencer did not go idle after the last span");

  a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata[29:24] == '0)) |=> in_tready)
    else $error("zero radius disc started a column walk");

  a_load_starts_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cfsg_pkg::ST_LOAD) |=>
      ((state_r == cfsg_pkg::ST_ROOT) && (step_r == SCW'(NSTEP - 1))))
    else $error("root iteration not started from the top step");

  a_drawable_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (!out_tdata[13] && !out_tdata[26]))
    else $error("drawable span with negative column or top row");

endmodule
